[hw/rtl/pib_pkg.sv]
package pib_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int TS_BITS = WORD_BITS - 1;
  localparam int PROD_BITS = WORD_BITS + TS_BITS;
  localparam int DIV_STAGES = WORD_BITS;
  // Integration stages, one compare stage, divider stages, one select stage.
  localparam int NSTAGE = 7 + DIV_STAGES + 1;
  localparam int ADDR_BITS = 5;

  typedef logic signed [WORD_BITS-1:0] word_t;

  // Boundary kinds in mode bits 2:1.
  localparam logic [1:0] BND_PERIODIC = 2'd0;
  localparam logic [1:0] BND_ELASTIC  = 2'd1;
  localparam logic [1:0] BND_DIFFUSE  = 2'd2;

  // Register indexes.
  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_TIMESTEP  = 3'd1;
  localparam logic [2:0] REG_BOX_MIN_X = 3'd2;
  localparam logic [2:0] REG_BOX_MIN_Y = 3'd3;
  localparam logic [2:0] REG_BOX_MIN_Z = 3'd4;
  localparam logic [2:0] REG_BOX_MAX_X = 3'd5;
  localparam logic [2:0] REG_BOX_MAX_Y = 3'd6;
  localparam logic [2:0] REG_BOX_MAX_Z = 3'd7;

  // Per-lane view of the configuration.
  typedef struct packed {
    logic [TS_BITS-1:0] ts;
    logic               leap;
    logic [1:0]         kind;
    word_t              lo;
    word_t              hi;
  } lane_cfg_t;

  // Adds floor(signed product / 2^FRAC_BITS) to base and saturates.
  function automatic word_t step_sat(word_t base, logic [PROD_BITS-1:0] prod, logic neg);
    logic signed [PROD_BITS:0]   sp;
    logic signed [PROD_BITS:0]   sh;
    logic signed [PROD_BITS+1:0] sum;
    sp = neg ? -$signed({1'b0, prod}) : $signed({1'b0, prod});
    sh = sp >>> FRAC_BITS;
    sum = {{(PROD_BITS+2-WORD_BITS){base[WORD_BITS-1]}}, base} + {sh[PROD_BITS], sh};
    if ((&sum[PROD_BITS+1:WORD_BITS-1]) || !(|sum[PROD_BITS+1:WORD_BITS-1])) begin
      return sum[WORD_BITS-1:0];
    end
    return sum[PROD_BITS+1] ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
  endfunction

endpackage

[hw/rtl/pib_if.sv]
interface pib_in_if import pib_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t pos_x;
  word_t pos_y;
  word_t pos_z;
  word_t vel_x;
  word_t vel_y;
  word_t vel_z;
  word_t acc_x;
  word_t acc_y;
  word_t acc_z;
  logic  deleted_in;
  logic  last_in;
  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  acc_x, acc_y, acc_z, deleted_in, last_in, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                acc_x, acc_y, acc_z, deleted_in, last_in, output ready);
endinterface

interface pib_out_if import pib_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t new_pos_x;
  word_t new_pos_y;
  word_t new_pos_z;
  word_t new_vel_x;
  word_t new_vel_y;
  word_t new_vel_z;
  logic  deleted_out;
  logic  removed_now;
  logic  last_out;
  modport source (output valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
                  new_vel_z, deleted_out, removed_now, last_out, input ready);
  modport sink (input valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
                new_vel_z, deleted_out, removed_now, last_out, output ready);
endinterface

[hw/rtl/pib_lane.sv]
module pib_lane import pib_pkg::*; (
  input  logic              clk,
  input  logic [NSTAGE-1:0] acc,
  input  lane_cfg_t         cfg,
  input  word_t             p_in,
  input  word_t             v_in,
  input  word_t             a_in,
  input  logic              del_in,
  output word_t             pos_out,
  output word_t             vel_out,
  output logic              outside_out
);

  localparam int D0 = 7;
  localparam int FS = NSTAGE - 1;

  word_t                p0_r, v0_r, p1_r, v1_r, p2_r, v2_r, vn2_r, p3_r, vn3_r;
  word_t                p4_r, vn4_r, pn5_r, vn5_r;
  logic [WORD_BITS-1:0] amag0_r, mag3_r;
  logic                 aneg0_r, neg1_r, neg3_r, neg4_r;
  logic                 del0_r, del1_r, del2_r, del3_r, del4_r, del5_r;
  logic [PROD_BITS-1:0] prod1_r, prod4_r;
  word_t                rate3;

  logic [WORD_BITS-1:0] rem_r [DIV_STAGES+1];
  logic [WORD_BITS-1:0] dsh_r [DIV_STAGES+1];
  logic [WORD_BITS-1:0] len_r [DIV_STAGES+1];
  word_t                pc_r  [DIV_STAGES+1];
  word_t                vc_r  [DIV_STAGES+1];
  logic                 out_r [DIV_STAGES+1];
  logic                 act_r [DIV_STAGES+1];
  logic                 abv_r [DIV_STAGES+1];
  logic                 q_r   [DIV_STAGES+1];

  logic                 above6, below6, degen6;
  logic [WORD_BITS:0]   trial [DIV_STAGES];
  logic                 ge    [DIV_STAGES];
  word_t                pos_r, vel_r, fold_pos;
  logic                 outside_r;

  // Velocity update: multiply, then add and saturate.
  always_ff @(posedge clk) begin
    if (acc[0]) begin
      p0_r    <= p_in;
      v0_r    <= v_in;
      aneg0_r <= a_in[WORD_BITS-1];
      amag0_r <= a_in[WORD_BITS-1] ? WORD_BITS'(-a_in) : a_in;
      del0_r  <= del_in;
    end
    if (acc[1]) begin
      prod1_r <= PROD_BITS'({{TS_BITS{1'b0}}, amag0_r} * {{WORD_BITS{1'b0}}, cfg.ts});
      p1_r    <= p0_r;
      v1_r    <= v0_r;
      neg1_r  <= aneg0_r;
      del1_r  <= del0_r;
    end
    if (acc[2]) begin
      vn2_r  <= del1_r ? v1_r : step_sat(v1_r, prod1_r, neg1_r);
      p2_r   <= p1_r;
      v2_r   <= v1_r;
      del2_r <= del1_r;
    end
  end

  // Leapfrog moves with the new velocity, explicit with the old one.
  assign rate3 = cfg.leap ? vn2_r : v2_r;

  // Position update.
  always_ff @(posedge clk) begin
    if (acc[3]) begin
      neg3_r <= rate3[WORD_BITS-1];
      mag3_r <= rate3[WORD_BITS-1] ? WORD_BITS'(-rate3) : rate3;
      p3_r   <= p2_r;
      vn3_r  <= vn2_r;
      del3_r <= del2_r;
    end
    if (acc[4]) begin
      prod4_r <= PROD_BITS'({{TS_BITS{1'b0}}, mag3_r} * {{WORD_BITS{1'b0}}, cfg.ts});
      p4_r    <= p3_r;
      vn4_r   <= vn3_r;
      neg4_r  <= neg3_r;
      del4_r  <= del3_r;
    end
    if (acc[5]) begin
      pn5_r  <= del4_r ? p4_r : step_sat(p4_r, prod4_r, neg4_r);
      vn5_r  <= vn4_r;
      del5_r <= del4_r;
    end
  end

  // Box test and the distance to fold.
  assign above6 = pn5_r > cfg.hi;
  assign below6 = pn5_r < cfg.lo;
  assign degen6 = cfg.hi <= cfg.lo;

  always_ff @(posedge clk) begin
    if (acc[6]) begin
      rem_r[0] <= '0;
      dsh_r[0] <= above6 ? WORD_BITS'(pn5_r - cfg.lo) : WORD_BITS'(cfg.lo - pn5_r);
      len_r[0] <= WORD_BITS'(cfg.hi - cfg.lo);
      pc_r[0]  <= pn5_r;
      vc_r[0]  <= vn5_r;
      out_r[0] <= !del5_r && (above6 || below6);
      act_r[0] <= !del5_r && (above6 || below6) && !degen6 && !cfg.kind[1];
      abv_r[0] <= above6;
      q_r[0]   <= 1'b0;
    end
  end

  // Restoring divider, one quotient bit per stage; only the remainder and
  // the quotient's low bit are needed.
  always_comb begin
    for (int j = 0; j < DIV_STAGES; j++) begin
      trial[j] = {rem_r[j], dsh_r[j][WORD_BITS-1]};
      ge[j]    = trial[j] >= {1'b0, len_r[j]};
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < DIV_STAGES; j++) begin
      if (acc[D0+j]) begin
        rem_r[j+1] <= ge[j] ? WORD_BITS'(trial[j] - {1'b0, len_r[j]})
                            : trial[j][WORD_BITS-1:0];
        dsh_r[j+1] <= {dsh_r[j][WORD_BITS-2:0], 1'b0};
        len_r[j+1] <= len_r[j];
        pc_r[j+1]  <= pc_r[j];
        vc_r[j+1]  <= vc_r[j];
        out_r[j+1] <= out_r[j];
        act_r[j+1] <= act_r[j];
        abv_r[j+1] <= abv_r[j];
        q_r[j+1]   <= ge[j];
      end
    end
  end

  // Periodic wraps by direction; elastic picks the side by bounce parity.
  always_comb begin
    fold_pos = pc_r[DIV_STAGES];
    if (act_r[DIV_STAGES]) begin
      if (cfg.kind == BND_PERIODIC) begin
        fold_pos = abv_r[DIV_STAGES] ? word_t'(cfg.lo + rem_r[DIV_STAGES])
                                     : word_t'(cfg.hi - rem_r[DIV_STAGES]);
      end else begin
        fold_pos = q_r[DIV_STAGES] ? word_t'(cfg.hi - rem_r[DIV_STAGES])
                                   : word_t'(cfg.lo + rem_r[DIV_STAGES]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc[FS]) begin
      pos_r     <= fold_pos;
      vel_r     <= vc_r[DIV_STAGES];
      outside_r <= out_r[DIV_STAGES];
    end
  end

  assign pos_out     = pos_r;
  assign vel_out     = vel_r;
  assign outside_out = outside_r;

endmodule

[hw/rtl/particle_integrate_boundary_step.sv]
// Channel  Direction  Contents
// in_ch    sink       one particle: position, velocity, acceleration, flags
// out_ch   source     one updated particle with deleted, removed and last
// cfg      APB        mode, timestep, box bounds (byte address 4*index)
//
// One item is accepted per cycle while out_ch is not stalled; each result
// passes through the two multiply/saturate steps and the 32-stage remainder
// pipeline of each axis lane.
// Every stage holds its item until the next stage frees, so bubbles close up
// and the input keeps flowing while a finished result waits, until the empty
// stages behind it are filled.
// Reset (rst_n, synchronous) empties the pipeline and loads register defaults.
module particle_integrate_boundary_step import pib_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  pib_in_if.sink               in_ch,
  pib_out_if.source            out_ch,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [2:0]         mode_r;
  logic [TS_BITS-1:0] ts_r;
  word_t              lo_r [3];
  word_t              hi_r [3];
  logic [2:0]         idx;

  logic [NSTAGE-1:0]  v_r;
  logic [NSTAGE-1:0]  del_r;
  logic [NSTAGE-1:0]  last_r;
  logic [NSTAGE-1:0]  acc;

  lane_cfg_t          lcfg [3];
  word_t              pin [3], vin [3], ain [3], pout [3], vout [3];
  logic [2:0]         outside;
  logic               removed;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 3'd1;
      ts_r   <= TS_BITS'(1 << FRAC_BITS);
      for (int i = 0; i < 3; i++) begin
        lo_r[i] <= '0;
        hi_r[i] <= word_t'(1 << FRAC_BITS);
      end
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_MODE:      mode_r  <= pwdata[2:0];
        REG_TIMESTEP:  ts_r    <= pwdata[TS_BITS-1:0];
        REG_BOX_MIN_X: lo_r[0] <= pwdata;
        REG_BOX_MIN_Y: lo_r[1] <= pwdata;
        REG_BOX_MIN_Z: lo_r[2] <= pwdata;
        REG_BOX_MAX_X: hi_r[0] <= pwdata;
        REG_BOX_MAX_Y: hi_r[1] <= pwdata;
        REG_BOX_MAX_Z: hi_r[2] <= pwdata;
        default:       mode_r  <= mode_r;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (idx)
      REG_MODE:      prdata = {29'd0, mode_r};
      REG_TIMESTEP:  prdata = {1'b0, ts_r};
      REG_BOX_MIN_X: prdata = lo_r[0];
      REG_BOX_MIN_Y: prdata = lo_r[1];
      REG_BOX_MIN_Z: prdata = lo_r[2];
      REG_BOX_MAX_X: prdata = hi_r[0];
      REG_BOX_MAX_Y: prdata = hi_r[1];
      REG_BOX_MAX_Z: prdata = hi_r[2];
      default:       prdata = '0;
    endcase
  end

  // A stage loads when it is empty or its item moves on.
  always_comb begin
    logic leave;
    leave = out_ch.ready;
    for (int k = NSTAGE - 1; k >= 0; k--) begin
      acc[k] = !v_r[k] || leave;
      leave  = acc[k];
    end
  end

  assign in_ch.ready = acc[0];

  // Valid and flag pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (acc[0]) v_r[0] <= in_ch.valid;
      for (int k = 1; k < NSTAGE; k++) begin
        if (acc[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc[0]) begin
      del_r[0]  <= in_ch.deleted_in;
      last_r[0] <= in_ch.last_in;
    end
    for (int k = 1; k < NSTAGE; k++) begin
      if (acc[k]) begin
        del_r[k]  <= del_r[k-1];
        last_r[k] <= last_r[k-1];
      end
    end
  end

  // Axis lanes.
  assign pin[0] = in_ch.pos_x;
  assign pin[1] = in_ch.pos_y;
  assign pin[2] = in_ch.pos_z;
  assign vin[0] = in_ch.vel_x;
  assign vin[1] = in_ch.vel_y;
  assign vin[2] = in_ch.vel_z;
  assign ain[0] = in_ch.acc_x;
  assign ain[1] = in_ch.acc_y;
  assign ain[2] = in_ch.acc_z;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    assign lcfg[g] = '{ts: ts_r, leap: mode_r[0], kind: mode_r[2:1],
                       lo: lo_r[g], hi: hi_r[g]};
    pib_lane u_lane (
      .clk         (clk),
      .acc         (acc),
      .cfg         (lcfg[g]),
      .p_in        (pin[g]),
      .v_in        (vin[g]),
      .a_in        (ain[g]),
      .del_in      (in_ch.deleted_in),
      .pos_out     (pout[g]),
      .vel_out     (vout[g]),
      .outside_out (outside[g])
    );
  end

  // Merge: diffuse boundary removes a particle outside on any axis.
  assign removed = (mode_r[2:1] == BND_DIFFUSE) && (|outside);

  assign out_ch.valid       = v_r[NSTAGE-1];
  assign out_ch.new_pos_x   = pout[0];
  assign out_ch.new_pos_y   = pout[1];
  assign out_ch.new_pos_z   = pout[2];
  assign out_ch.new_vel_x   = vout[0];
  assign out_ch.new_vel_y   = vout[1];
  assign out_ch.new_vel_z   = vout[2];
  assign out_ch.deleted_out = del_r[NSTAGE-1] || removed;
  assign out_ch.removed_now = removed;
  assign out_ch.last_out    = last_r[NSTAGE-1];

  // Checks.
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> v_r[0])
    else $error("accepted item did not enter the first stage");

  a_removed_deleted: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.removed_now |-> out_ch.deleted_out)
    else $error("removed particle not flagged deleted");

  a_removed_diffuse: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.removed_now |-> mode_r[2:1] == BND_DIFFUSE)
    else $error("removal outside diffuse mode");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.new_pos_x)
      && $stable(out_ch.last_out))
    else $error("stalled result lost");

endmodule
